### hw/rtl/sam_pkg.sv
// ----------------------------------------------------------------------------
// sam_pkg
// Shared constants, micro-operation codes and controller/datapath structs
// for the suffix automaton matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package sam_pkg;

	localparam int MAX_TOKENS_DEF  = 4096;
	localparam int TOKEN_BITS_DEF  = 20;
	localparam int STATE_DEPTH_DEF = 8192;
	localparam int EDGE_DEPTH_DEF  = 12288;

	// result field widths
	localparam int START_W    = 12;
	localparam int END_W      = 13;
	localparam int MLEN_W     = 13;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_USER_W = 2;

	// datapath micro-operations
	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_NOP      = 5'd0;
	localparam logic [OP_W-1:0] OP_INIT     = 5'd1;
	localparam logic [OP_W-1:0] OP_CLEAR    = 5'd2;
	localparam logic [OP_W-1:0] OP_START    = 5'd3;
	localparam logic [OP_W-1:0] OP_LK_RD    = 5'd4;
	localparam logic [OP_W-1:0] OP_LK_HEAD  = 5'd5;
	localparam logic [OP_W-1:0] OP_LK_STEP  = 5'd6;
	localparam logic [OP_W-1:0] OP_M_HIT    = 5'd7;
	localparam logic [OP_W-1:0] OP_M_MISS   = 5'd8;
	localparam logic [OP_W-1:0] OP_M_LINK   = 5'd9;
	localparam logic [OP_W-1:0] OP_RES_RD   = 5'd10;
	localparam logic [OP_W-1:0] OP_RES      = 5'd11;
	localparam logic [OP_W-1:0] OP_G_RD     = 5'd12;
	localparam logic [OP_W-1:0] OP_G_CUR    = 5'd13;
	localparam logic [OP_W-1:0] OP_G_PUT    = 5'd14;
	localparam logic [OP_W-1:0] OP_Q_RD     = 5'd15;
	localparam logic [OP_W-1:0] OP_G_LINKQ  = 5'd16;
	localparam logic [OP_W-1:0] OP_CLONE    = 5'd17;
	localparam logic [OP_W-1:0] OP_CP_RD    = 5'd18;
	localparam logic [OP_W-1:0] OP_CP_PUT   = 5'd19;
	localparam logic [OP_W-1:0] OP_RD_SET   = 5'd20;
	localparam logic [OP_W-1:0] OP_CL_LQ    = 5'd21;
	localparam logic [OP_W-1:0] OP_CL_LC    = 5'd22;
	localparam logic [OP_W-1:0] OP_G_END    = 5'd23;
	localparam logic [OP_W-1:0] OP_EMIT     = 5'd24;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            len_min;
	} sam_cmd_t;

	typedef struct packed {
		logic head_none;
		logic step_hit;
		logic next_none;
		logic hit;
		logic s_root;
		logic slink_none;
		logic lens_eq;
		logic ee_none;
		logic redirect_ok;
		logic full;
		logic out_free;
	} sam_stat_t;

endpackage

`default_nettype wire

### hw/rtl/sam_dp.sv
// ----------------------------------------------------------------------------
// sam_dp
// Datapath: automaton stores, working registers and result register,
// driven one micro-operation per cycle by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module sam_dp
	import sam_pkg::*;
#(
	parameter int MAX_TOKENS  = MAX_TOKENS_DEF,
	parameter int TOKEN_BITS  = TOKEN_BITS_DEF,
	parameter int STATE_DEPTH = STATE_DEPTH_DEF,
	parameter int EDGE_DEPTH  = EDGE_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire sam_cmd_t              cmd,
	output sam_stat_t                  stat,
	input  wire logic [TOKEN_BITS-1:0] in_token,
	input  wire logic                  m_tready,
	output logic                       m_tvalid,
	output logic [OUT_DATA_W-1:0]      m_tdata,
	output logic [OUT_USER_W-1:0]      m_tuser
);

	localparam int SA = $clog2(STATE_DEPTH);
	localparam int SW = $clog2(STATE_DEPTH + 1);
	localparam int EA = $clog2(EDGE_DEPTH);
	localparam int EW = $clog2(EDGE_DEPTH + 1);
	localparam int LW = $clog2(MAX_TOKENS + 1);
	localparam int FW = $clog2(MAX_TOKENS);
	localparam logic [SW-1:0] NONE_S = {SW{1'b1}};
	localparam logic [EW-1:0] NONE_E = {EW{1'b1}};

	// stores
	logic [SW-1:0]         link_mem  [STATE_DEPTH];
	logic [LW-1:0]         len_mem   [STATE_DEPTH];
	logic [FW-1:0]         fend_mem  [STATE_DEPTH];
	logic [EW-1:0]         fedge_mem [STATE_DEPTH];
	logic [TOKEN_BITS-1:0] etok_mem  [EDGE_DEPTH];
	logic [SW-1:0]         etgt_mem  [EDGE_DEPTH];
	logic [EW-1:0]         enext_mem [EDGE_DEPTH];

	logic [SW-1:0]         link_rd;
	logic [LW-1:0]         len_rd;
	logic [FW-1:0]         fend_rd;
	logic [EW-1:0]         fedge_rd;
	logic [TOKEN_BITS-1:0] etok_rd;
	logic [SW-1:0]         etgt_rd;
	logic [EW-1:0]         enext_rd;

	logic                  st_re, e_re;
	logic [SA-1:0]         st_ra, st_wa;
	logic [EA-1:0]         e_ra, e_wa;
	logic                  we_link, we_len, we_fend, we_fedge;
	logic [SW-1:0]         wd_link;
	logic [LW-1:0]         wd_len;
	logic [FW-1:0]         wd_fend;
	logic [EW-1:0]         wd_fedge;
	logic                  we_etok, we_etgt, we_enext;
	logic [TOKEN_BITS-1:0] wd_etok;
	logic [SW-1:0]         wd_etgt;
	logic [EW-1:0]         wd_enext;

	// architectural registers
	logic [LW-1:0] token_count_q;
	logic [SW-1:0] last_q, mstate_q, sc_q;
	logic [LW-1:0] mlen_q;
	logic [EW-1:0] ec_q;
	logic          m_tvalid_q;

	// working registers
	logic [TOKEN_BITS-1:0] tok_q;
	logic [SW-1:0]         s_q, slink_q, hit_tgt_q, q_q, cur_q, cl_q;
	logic [LW-1:0]         len_q, slen_q;
	logic [EW-1:0]         e_q, head_q, hit_e_q, ee_q, clhead_q;
	logic                  hit_q, full_q;
	logic                  res_found_q, res_full_q;
	logic [START_W-1:0]    res_start_q;
	logic [END_W-1:0]      res_end_q;
	logic [MLEN_W-1:0]     res_len_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [OUT_USER_W-1:0] m_tuser_q;

	logic          full_c, room_c, tok_eq_c;
	logic [SW:0]   sc_plus2_c;
	logic [31:0]   sum_end_c, sum_start_c;

	assign sc_plus2_c  = {1'b0, sc_q} + (SW+1)'(2);
	assign full_c      = (token_count_q >= LW'(MAX_TOKENS)) ||
	                     (sc_plus2_c > (SW+1)'(STATE_DEPTH));
	assign room_c      = ec_q < EW'(EDGE_DEPTH);
	assign tok_eq_c    = etok_rd == tok_q;
	assign sum_end_c   = 32'(fend_rd) + 32'd1;
	assign sum_start_c = sum_end_c - 32'(len_q);

	always_comb begin
		stat.head_none   = fedge_rd >= EW'(EDGE_DEPTH);
		stat.step_hit    = tok_eq_c;
		stat.next_none   = enext_rd >= EW'(EDGE_DEPTH);
		stat.hit         = hit_q;
		stat.s_root      = s_q == '0;
		stat.slink_none  = slink_q == NONE_S;
		stat.lens_eq     = (slen_q + LW'(1)) == len_rd;
		stat.ee_none     = ee_q >= EW'(EDGE_DEPTH);
		stat.redirect_ok = hit_q && (hit_tgt_q == q_q);
		stat.full        = full_q;
		stat.out_free    = !m_tvalid_q || m_tready;
	end

	// store addressing per micro-operation
	always_comb begin
		st_re    = 1'b0;
		st_ra    = s_q[SA-1:0];
		e_re     = 1'b0;
		e_ra     = fedge_rd[EA-1:0];
		st_wa    = '0;
		we_link  = 1'b0;
		wd_link  = '0;
		we_len   = 1'b0;
		wd_len   = '0;
		we_fend  = 1'b0;
		wd_fend  = '0;
		we_fedge = 1'b0;
		wd_fedge = NONE_E;
		e_wa     = ec_q[EA-1:0];
		we_etok  = 1'b0;
		wd_etok  = tok_q;
		we_etgt  = 1'b0;
		wd_etgt  = cur_q;
		we_enext = 1'b0;
		wd_enext = head_q;
		case (cmd.op)
			OP_INIT, OP_CLEAR: begin
				// root: no link, length zero, no edges
				we_link  = 1'b1;
				wd_link  = NONE_S;
				we_len   = 1'b1;
				we_fend  = 1'b1;
				we_fedge = 1'b1;
			end
			OP_LK_RD, OP_RES_RD: begin
				st_re = 1'b1;
			end
			OP_LK_HEAD: begin
				e_re = 1'b1;
			end
			OP_LK_STEP: begin
				e_re = 1'b1;
				e_ra = enext_rd[EA-1:0];
			end
			OP_G_RD: begin
				st_re = 1'b1;
				st_ra = last_q[SA-1:0];
			end
			OP_G_CUR: begin
				st_wa    = sc_q[SA-1:0];
				we_link  = 1'b1;
				we_len   = 1'b1;
				wd_len   = len_rd + LW'(1);
				we_fend  = 1'b1;
				wd_fend  = token_count_q[FW-1:0];
				we_fedge = 1'b1;
			end
			OP_G_PUT: begin
				st_wa    = s_q[SA-1:0];
				we_fedge = room_c;
				wd_fedge = ec_q;
				we_etok  = room_c;
				we_etgt  = room_c;
				we_enext = room_c;
			end
			OP_Q_RD: begin
				st_re = 1'b1;
				st_ra = hit_tgt_q[SA-1:0];
			end
			OP_G_LINKQ: begin
				st_wa   = cur_q[SA-1:0];
				we_link = 1'b1;
				wd_link = q_q;
			end
			OP_CLONE: begin
				st_wa    = sc_q[SA-1:0];
				we_link  = 1'b1;
				wd_link  = link_rd;
				we_len   = 1'b1;
				wd_len   = slen_q + LW'(1);
				we_fend  = 1'b1;
				wd_fend  = fend_rd;
				we_fedge = 1'b1;
			end
			OP_CP_RD: begin
				e_re = 1'b1;
				e_ra = ee_q[EA-1:0];
			end
			OP_CP_PUT: begin
				st_wa    = cl_q[SA-1:0];
				we_fedge = room_c;
				wd_fedge = ec_q;
				we_etok  = room_c;
				wd_etok  = etok_rd;
				we_etgt  = room_c;
				wd_etgt  = etgt_rd;
				we_enext = room_c;
				wd_enext = clhead_q;
			end
			OP_RD_SET: begin
				e_wa    = hit_e_q[EA-1:0];
				we_etgt = 1'b1;
				wd_etgt = cl_q;
			end
			OP_CL_LQ: begin
				st_wa   = q_q[SA-1:0];
				we_link = 1'b1;
				wd_link = cl_q;
			end
			OP_CL_LC: begin
				st_wa   = cur_q[SA-1:0];
				we_link = 1'b1;
				wd_link = cl_q;
			end
			default: begin
			end
		endcase
	end

	// state store
	always_ff @(posedge clk) begin
		if (we_link)  link_mem[st_wa]  <= wd_link;
		if (we_len)   len_mem[st_wa]   <= wd_len;
		if (we_fend)  fend_mem[st_wa]  <= wd_fend;
		if (we_fedge) fedge_mem[st_wa] <= wd_fedge;
		if (st_re) begin
			link_rd  <= link_mem[st_ra];
			len_rd   <= len_mem[st_ra];
			fend_rd  <= fend_mem[st_ra];
			fedge_rd <= fedge_mem[st_ra];
		end
	end

	// edge store
	always_ff @(posedge clk) begin
		if (we_etok)  etok_mem[e_wa]  <= wd_etok;
		if (we_etgt)  etgt_mem[e_wa]  <= wd_etgt;
		if (we_enext) enext_mem[e_wa] <= wd_enext;
		if (e_re) begin
			etok_rd  <= etok_mem[e_ra];
			etgt_rd  <= etgt_mem[e_ra];
			enext_rd <= enext_mem[e_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_count_q <= '0;
			last_q        <= '0;
			mstate_q      <= '0;
			mlen_q        <= '0;
			sc_q          <= SW'(1);
			ec_q          <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			// result held until taken, set again on emit
			m_tvalid_q <= (cmd.op == OP_EMIT) || (m_tvalid_q && !m_tready);
			case (cmd.op)
				OP_INIT, OP_CLEAR: begin
					token_count_q <= '0;
					last_q        <= '0;
					mstate_q      <= '0;
					mlen_q        <= '0;
					sc_q          <= SW'(1);
					ec_q          <= '0;
				end
				OP_RES: begin
					mstate_q <= s_q;
					mlen_q   <= len_q;
				end
				OP_G_CUR, OP_CLONE: sc_q <= sc_q + SW'(1);
				OP_G_PUT, OP_CP_PUT: begin
					if (room_c) ec_q <= ec_q + EW'(1);
				end
				OP_G_END: begin
					last_q        <= cur_q;
					token_count_q <= token_count_q + LW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CLEAR: begin
				res_found_q <= 1'b0;
				res_full_q  <= 1'b0;
				res_start_q <= '0;
				res_end_q   <= '0;
				res_len_q   <= '0;
			end
			OP_START: begin
				tok_q  <= in_token;
				s_q    <= mstate_q;
				len_q  <= mlen_q;
				full_q <= full_c;
			end
			OP_LK_HEAD: begin
				head_q  <= fedge_rd;
				e_q     <= fedge_rd;
				slink_q <= link_rd;
				slen_q  <= len_rd;
				if (cmd.len_min && (len_rd < len_q)) len_q <= len_rd;
				if (fedge_rd >= EW'(EDGE_DEPTH)) hit_q <= 1'b0;
			end
			OP_LK_STEP: begin
				if (tok_eq_c) begin
					hit_q     <= 1'b1;
					hit_e_q   <= e_q;
					hit_tgt_q <= etgt_rd;
				end else begin
					e_q <= enext_rd;
					if (enext_rd >= EW'(EDGE_DEPTH)) hit_q <= 1'b0;
				end
			end
			OP_M_HIT: begin
				s_q   <= hit_tgt_q;
				len_q <= len_q + LW'(1);
			end
			OP_M_MISS: begin
				s_q   <= '0;
				len_q <= '0;
			end
			OP_M_LINK: s_q <= (slink_q == NONE_S) ? '0 : slink_q;
			OP_RES: begin
				res_found_q <= len_q != '0;
				res_full_q  <= full_q;
				res_len_q   <= MLEN_W'(len_q);
				if (len_q != '0) begin
					res_start_q <= sum_start_c[START_W-1:0];
					res_end_q   <= sum_end_c[END_W-1:0];
				end else begin
					res_start_q <= '0;
					res_end_q   <= '0;
				end
			end
			OP_G_CUR: begin
				cur_q <= sc_q;
				s_q   <= last_q;
			end
			OP_G_PUT, OP_RD_SET: s_q <= slink_q;
			OP_Q_RD: q_q <= hit_tgt_q;
			OP_CLONE: begin
				cl_q     <= sc_q;
				ee_q     <= fedge_rd;
				clhead_q <= NONE_E;
			end
			OP_CP_PUT: begin
				ee_q <= enext_rd;
				if (room_c) clhead_q <= ec_q;
			end
			OP_EMIT: begin
				m_tdata_q <= OUT_DATA_W'({res_len_q, res_end_q, res_start_q});
				m_tuser_q <= {res_full_q, res_found_q};
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

### hw/rtl/sam_ctrl.sv
// ----------------------------------------------------------------------------
// sam_ctrl
// Controller: sequences match, edge lookups, growth and cloning as
// micro-operations issued to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module sam_ctrl
	import sam_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	input  wire logic      mode,
	input  wire sam_stat_t stat,
	output sam_cmd_t       cmd
);

	localparam logic [4:0] ST_INIT = 5'd0;
	localparam logic [4:0] ST_IDLE = 5'd1;
	localparam logic [4:0] ST_LK0  = 5'd2;
	localparam logic [4:0] ST_LK1  = 5'd3;
	localparam logic [4:0] ST_LK2  = 5'd4;
	localparam logic [4:0] ST_MT   = 5'd5;
	localparam logic [4:0] ST_RES0 = 5'd6;
	localparam logic [4:0] ST_RES1 = 5'd7;
	localparam logic [4:0] ST_G0   = 5'd8;
	localparam logic [4:0] ST_G1   = 5'd9;
	localparam logic [4:0] ST_PL   = 5'd10;
	localparam logic [4:0] ST_Q0   = 5'd11;
	localparam logic [4:0] ST_Q1   = 5'd12;
	localparam logic [4:0] ST_C0   = 5'd13;
	localparam logic [4:0] ST_C1   = 5'd14;
	localparam logic [4:0] ST_RD   = 5'd15;
	localparam logic [4:0] ST_CLE0 = 5'd16;
	localparam logic [4:0] ST_CLE1 = 5'd17;
	localparam logic [4:0] ST_GEND = 5'd18;
	localparam logic [4:0] ST_FIN  = 5'd19;

	// where a lookup returns to
	localparam logic [1:0] R_MATCH = 2'd0;
	localparam logic [1:0] R_G1    = 2'd1;
	localparam logic [1:0] R_RD    = 2'd2;

	logic [4:0] state_q, state_d, ret_st;
	logic [1:0] ret_q, ret_d;

	always_comb begin
		unique case (ret_q)
			R_G1:    ret_st = ST_PL;
			R_RD:    ret_st = ST_RD;
			default: ret_st = ST_MT;
		endcase
	end

	assign s_tready = state_q == ST_IDLE;

	always_comb begin
		state_d     = state_q;
		ret_d       = ret_q;
		cmd.op      = OP_NOP;
		cmd.len_min = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cmd.op  = OP_INIT;
				state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					if (mode) begin
						cmd.op  = OP_CLEAR;
						state_d = ST_FIN;
					end else begin
						cmd.op  = OP_START;
						ret_d   = R_MATCH;
						state_d = ST_LK0;
					end
				end
			end
			ST_LK0: begin
				cmd.op  = OP_LK_RD;
				state_d = ST_LK1;
			end
			ST_LK1: begin
				cmd.op      = OP_LK_HEAD;
				cmd.len_min = ret_q == R_MATCH;
				state_d     = stat.head_none ? ret_st : ST_LK2;
			end
			ST_LK2: begin
				cmd.op = OP_LK_STEP;
				if (stat.step_hit || stat.next_none) state_d = ret_st;
			end
			ST_MT: begin
				if (stat.hit) begin
					cmd.op  = OP_M_HIT;
					state_d = ST_RES0;
				end else if (stat.s_root) begin
					cmd.op  = OP_M_MISS;
					state_d = ST_RES0;
				end else begin
					cmd.op  = OP_M_LINK;
					state_d = ST_LK0;
				end
			end
			ST_RES0: begin
				cmd.op  = OP_RES_RD;
				state_d = ST_RES1;
			end
			ST_RES1: begin
				cmd.op  = OP_RES;
				state_d = stat.full ? ST_FIN : ST_G0;
			end
			ST_G0: begin
				cmd.op  = OP_G_RD;
				state_d = ST_G1;
			end
			ST_G1: begin
				cmd.op  = OP_G_CUR;
				ret_d   = R_G1;
				state_d = ST_LK0;
			end
			ST_PL: begin
				if (stat.hit) begin
					state_d = ST_Q0;
				end else begin
					cmd.op  = OP_G_PUT;
					state_d = stat.slink_none ? ST_GEND : ST_LK0;
				end
			end
			ST_Q0: begin
				cmd.op  = OP_Q_RD;
				state_d = ST_Q1;
			end
			ST_Q1: begin
				if (stat.lens_eq) begin
					cmd.op  = OP_G_LINKQ;
					state_d = ST_GEND;
				end else begin
					cmd.op  = OP_CLONE;
					state_d = ST_C0;
				end
			end
			ST_C0: begin
				if (stat.ee_none) begin
					state_d = ST_RD;
				end else begin
					cmd.op  = OP_CP_RD;
					state_d = ST_C1;
				end
			end
			ST_C1: begin
				cmd.op  = OP_CP_PUT;
				state_d = ST_C0;
			end
			ST_RD: begin
				if (stat.redirect_ok) begin
					cmd.op  = OP_RD_SET;
					ret_d   = R_RD;
					state_d = stat.slink_none ? ST_CLE0 : ST_LK0;
				end else begin
					state_d = ST_CLE0;
				end
			end
			ST_CLE0: begin
				cmd.op  = OP_CL_LQ;
				state_d = ST_CLE1;
			end
			ST_CLE1: begin
				cmd.op  = OP_CL_LC;
				state_d = ST_GEND;
			end
			ST_GEND: begin
				cmd.op  = OP_G_END;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.op  = OP_EMIT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			ret_q   <= R_MATCH;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/suffix_automaton_match_top.sv
// ----------------------------------------------------------------------------
// suffix_automaton_match_top
// Streaming longest-suffix matcher built on an online suffix automaton.
// ----------------------------------------------------------------------------
// Each input item carries a token (or, with tuser set, a clear command). For a
// token the block walks the automaton of all earlier tokens to find the longest
// suffix of the text that occurred before, reports its earliest occurrence, and
// then extends the automaton with the token, cloning a state where a split is
// needed. One result item leaves for each input item. Items are handled one at a
// time; the work for a token item grows with each state visited on a suffix
// link walk, each edge scanned in each edge list and each edge copied when a
// state is cloned, and a finished result may wait for the previous one to leave.
// Every lookup step goes through the single read port of the state and edge
// stores. Amortised over a run the work per token is constant. After reset the
// root state is written before the first item is taken. When the token count
// reaches MAX_TOKENS or the state store lacks room for two more states, the
// token is still matched but not added, and full_res is set.
// ----------------------------------------------------------------------------
`default_nettype none

module suffix_automaton_match_top
	import sam_pkg::*;
#(
	parameter int MAX_TOKENS  = MAX_TOKENS_DEF,
	parameter int TOKEN_BITS  = TOKEN_BITS_DEF,
	parameter int STATE_DEPTH = STATE_DEPTH_DEF,
	parameter int EDGE_DEPTH  = EDGE_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// token
	input  wire logic [((TOKEN_BITS+7)/8)*8-1:0]    s_tdata,
	// mode (1 = clear)
	input  wire logic                               s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// match_start, match_end, match_length
	output logic [OUT_DATA_W-1:0]                   m_tdata,
	// found, full_res
	output logic [OUT_USER_W-1:0]                   m_tuser
);

	sam_cmd_t  cmd;
	sam_stat_t stat;

	// sequencer
	sam_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.mode     (s_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	// stores, working registers and result register
	sam_dp #(
		.MAX_TOKENS  (MAX_TOKENS),
		.TOKEN_BITS  (TOKEN_BITS),
		.STATE_DEPTH (STATE_DEPTH),
		.EDGE_DEPTH  (EDGE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_token (s_tdata[TOKEN_BITS-1:0]),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

### hw/rtl/sam_chk.sv
// ----------------------------------------------------------------------------
// sam_chk
// Port-level checks for the suffix automaton matcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sam_chk
	import sam_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata,
	input wire logic [OUT_USER_W-1:0] m_tuser
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one item in work at a time
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// no match means zero positions
	a_nf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[START_W+END_W+MLEN_W-1:0] == '0)
		else $error("positions set without a match");

	// a match has a nonzero length
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			m_tdata[START_W+END_W+MLEN_W-1:START_W+END_W] != '0)
		else $error("match with zero length");

endmodule

bind suffix_automaton_match_top sam_chk u_sam_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

### bench/suffix_automaton_match_top_tb.sv
// ----------------------------------------------------------------------------
// suffix_automaton_match_top_tb
// Self-checking bench for the streaming suffix automaton matcher: a directed
// table, then random token runs over a few repeating alphabets with clears,
// under several idling phases. Every result item is checked against the typed
// result where the table gives one, else against an independent automaton kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module suffix_automaton_match_top_tb;
	import sam_pkg::*;

	localparam int          TOK_W     = TOKEN_BITS_DEF;
	localparam int          IN_W      = ((TOK_W+7)/8)*8;
	localparam int          ST_DEPTH  = STATE_DEPTH_DEF;
	localparam int          ARC_DEPTH = EDGE_DEPTH_DEF;
	localparam int unsigned NIL       = 32'hFFFF_FFFF;
	localparam logic        MODE_TOKEN = 1'b0;
	localparam logic        MODE_CLEAR = 1'b1;
	localparam longint      CYCLE_LIMIT = 6_000_000;

	typedef struct packed {
		logic              found;
		logic [START_W-1:0] mstart;
		logic [END_W-1:0]   mend;
		logic [MLEN_W-1:0]  mlen;
		logic              full;
	} match_t;

	typedef struct {
		logic             mode;
		logic [TOK_W-1:0] tok;
		bit               typed;
		match_t           res;
	} row_t;

	logic                         clk;
	logic                         arst_n;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [IN_W-1:0]              s_tdata;
	logic                         s_tuser;
	logic                         m_tvalid;
	logic                         m_tready;
	logic [OUT_DATA_W-1:0]        m_tdata;
	logic [OUT_USER_W-1:0]        m_tuser;

	suffix_automaton_match_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	// ------------------------------------------------------------------
	// bench copy of the automaton
	// ------------------------------------------------------------------
	int unsigned lnk [ST_DEPTH];
	int unsigned lng [ST_DEPTH];
	int unsigned fend[ST_DEPTH];
	int unsigned head[ST_DEPTH];
	int unsigned atok [ARC_DEPTH];
	int unsigned atgt [ARC_DEPTH];
	int unsigned anext[ARC_DEPTH];
	int unsigned n_tokens, tail_state, cur_state, cur_len, n_states, n_arcs;

	match_t pending_matches[$];

	int  n_errors, n_results, n_found, n_full, n_clears, n_items;
	int  idle_src, stall_snk;
	longint cycles;

	// idling mix per random phase
	int src_phase[4] = '{0, 73, 0, 13};
	int snk_phase[4] = '{0, 0, 73, 13};

	function automatic void sam_clear();
		lnk[0] = NIL; lng[0] = 0; fend[0] = 0; head[0] = NIL;
		n_tokens = 0; tail_state = 0; cur_state = 0; cur_len = 0;
		n_states = 1; n_arcs = 0;
	endfunction

	// out-of-range state indexes fall back to the root
	function automatic int unsigned st_fix(int unsigned s);
		return (s < n_states && s < ST_DEPTH) ? s : 0;
	endfunction

	function automatic int unsigned find_arc(int unsigned s, int unsigned tok);
		int unsigned e, n;
		e = head[st_fix(s)];
		n = 0;
		while (e != NIL && e < ARC_DEPTH && n < ARC_DEPTH) begin
			if (atok[e] == tok)
				return e;
			e = anext[e];
			n++;
		end
		return NIL;
	endfunction

	function automatic void add_arc(int unsigned from, int unsigned tok, int unsigned to);
		int unsigned e, f;
		if (n_arcs >= ARC_DEPTH)
			return;
		f = st_fix(from);
		e = n_arcs++;
		atok[e] = tok; atgt[e] = to;
		anext[e] = head[f];
		head[f] = e;
	endfunction

	function automatic int unsigned add_state(int unsigned len, int unsigned lk,
			int unsigned fe);
		int unsigned s;
		s = n_states++;
		lnk[s] = lk; lng[s] = len; fend[s] = fe; head[s] = NIL;
		return s;
	endfunction

	// online extension of the automaton by one token
	function automatic void extend(int unsigned tok);
		int unsigned last, cur, p, g, e, q, cl, ee, n, pe;
		last = st_fix(tail_state);
		cur = add_state(lng[last] + 1, 0, n_tokens);
		p = last;
		g = 0;
		while (p != NIL && g < ST_DEPTH && find_arc(p, tok) == NIL) begin
			add_arc(p, tok, cur);
			p = lnk[st_fix(p)];
			g++;
		end
		if (p == NIL || g >= ST_DEPTH) begin
			lnk[cur] = 0;
		end else begin
			e = find_arc(p, tok);
			q = (e == NIL) ? 0 : st_fix(atgt[e]);
			p = st_fix(p);
			if (lng[p] + 1 == lng[q]) begin
				lnk[cur] = q;
			end else begin
				// split: clone q with the shorter length
				cl = add_state(lng[p] + 1, lnk[q], fend[q]);
				ee = head[q];
				n = 0;
				while (ee != NIL && ee < ARC_DEPTH && n < ARC_DEPTH) begin
					add_arc(cl, atok[ee], atgt[ee]);
					ee = anext[ee];
					n++;
				end
				g = 0;
				while (p != NIL && g < ST_DEPTH) begin
					pe = find_arc(p, tok);
					if (pe == NIL || atgt[pe] != q)
						break;
					atgt[pe] = cl;
					p = lnk[st_fix(p)];
					g++;
				end
				lnk[q] = cl;
				lnk[cur] = cl;
			end
		end
		tail_state = cur;
		n_tokens++;
	endfunction

	// longest earlier suffix match, then growth unless the store is full
	function automatic match_t match_token(logic mode, logic [TOK_W-1:0] tok_in);
		match_t r;
		int unsigned tok, s, len, e, g, l;
		bit full;
		r = '0;
		if (mode == MODE_CLEAR) begin
			sam_clear();
			return r;
		end
		tok = tok_in;
		s = st_fix(cur_state);
		len = cur_len;
		e = find_arc(s, tok);
		g = 0;
		while (s != 0 && e == NIL && g < ST_DEPTH) begin
			l = lnk[s];
			s = (l == NIL) ? 0 : st_fix(l);
			if (lng[s] < len)
				len = lng[s];
			e = find_arc(s, tok);
			g++;
		end
		if (e != NIL) begin
			s = st_fix(atgt[e]);
			len++;
		end else begin
			s = 0;
			len = 0;
		end
		cur_state = s;
		cur_len = len;
		if (len > 0) begin
			r.found  = 1'b1;
			r.mstart = START_W'(fend[s] + 1 - len);
			r.mend   = END_W'(fend[s] + 1);
		end
		r.mlen = MLEN_W'(len);
		full = (n_tokens >= MAX_TOKENS_DEF) || (n_states + 2 > ST_DEPTH);
		if (!full)
			extend(tok);
		r.full = full;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// sender: drives at the falling edge, accepts at the rising edge
	// ------------------------------------------------------------------
	task automatic send_item(logic mode, logic [TOK_W-1:0] tok, bit typed, match_t res);
		match_t predicted;
		while ($urandom_range(99) < idle_src) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= IN_W'(tok);
		do @(posedge clk); while (!s_tready);
		predicted = match_token(mode, tok);
		pending_matches = {pending_matches, typed ? res : predicted};
		n_items++;
		if (mode == MODE_CLEAR)
			n_clears++;
		@(negedge clk);
	endtask

	// a run over a small alphabet of full-width tokens so matches are common
	task automatic send_run(int count, int n_sym, int clear_pct);
		logic [TOK_W-1:0] sym[8];
		logic [TOK_W-1:0] t;
		foreach (sym[i])
			sym[i] = TOK_W'($urandom);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < clear_pct)
				send_item(MODE_CLEAR, TOK_W'($urandom), 1'b0, '0);
			else begin
				// occasional fresh token as noise
				t = ($urandom_range(19) == 0) ? TOK_W'($urandom)
				                              : sym[$urandom_range(n_sym - 1)];
				send_item(MODE_TOKEN, t, 1'b0, '0);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// receiver: stalls at random, checks each result item in order
	// ------------------------------------------------------------------
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= stall_snk);

	always @(posedge clk) begin
		match_t got, want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("suffix_automaton_match_top_tb: errors");
			$finish;
		end
		if (m_tvalid && m_tready) begin
			// user: found, full_res; data: start, end, length from bit 0 up
			got.found  = m_tuser[0];
			got.full   = m_tuser[1];
			got.mstart = m_tdata[START_W-1:0];
			got.mend   = m_tdata[START_W +: END_W];
			got.mlen   = m_tdata[START_W+END_W +: MLEN_W];
			n_results++;
			if (pending_matches.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected result item %p", got);
			end else begin
				want = pending_matches.pop_front();
				if (got.found) n_found++;
				if (got.full)  n_full++;
				if (got !== want) begin
					n_errors++;
					if (n_errors <= 10)
						$display("result %0d mismatch: expected %p, got %p",
							n_results, want, got);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// directed table; typed results only where obvious
	// ------------------------------------------------------------------
	row_t dir_rows[] = '{
		'{MODE_TOKEN, 20'h00000, 1'b1, '{1'b0, 12'd0, 13'd0, 13'd0, 1'b0}},
		'{MODE_TOKEN, 20'h00000, 1'b1, '{1'b1, 12'd0, 13'd1, 13'd1, 1'b0}},
		'{MODE_TOKEN, 20'hFFFFF, 1'b1, '{1'b0, 12'd0, 13'd0, 13'd0, 1'b0}},
		'{MODE_CLEAR, 20'hFFFFF, 1'b1, '{1'b0, 12'd0, 13'd0, 13'd0, 1'b0}},
		'{MODE_TOKEN, 20'hFFFFF, 1'b1, '{1'b0, 12'd0, 13'd0, 13'd0, 1'b0}},
		'{MODE_TOKEN, 20'hAAAAA, 1'b0, '0},
		'{MODE_TOKEN, 20'h55555, 1'b0, '0},
		'{MODE_TOKEN, 20'hAAAAA, 1'b0, '0},
		'{MODE_TOKEN, 20'h55555, 1'b0, '0},
		'{MODE_TOKEN, 20'hAAAAA, 1'b0, '0},
		'{MODE_TOKEN, 20'h12345, 1'b0, '0},
		'{MODE_TOKEN, 20'hAAAAA, 1'b0, '0},
		'{MODE_TOKEN, 20'h55555, 1'b0, '0},
		'{MODE_TOKEN, 20'h12345, 1'b0, '0},
		'{MODE_TOKEN, 20'hAAAAA, 1'b0, '0},
		'{MODE_TOKEN, 20'hAAAAA, 1'b0, '0},
		'{MODE_TOKEN, 20'hAAAAA, 1'b0, '0},
		'{MODE_CLEAR, 20'h00000, 1'b1, '{1'b0, 12'd0, 13'd0, 13'd0, 1'b0}},
		'{MODE_TOKEN, 20'h00001, 1'b1, '{1'b0, 12'd0, 13'd0, 13'd0, 1'b0}},
		'{MODE_TOKEN, 20'h80000, 1'b0, '0},
		'{MODE_TOKEN, 20'h00001, 1'b0, '0},
		'{MODE_TOKEN, 20'h80000, 1'b0, '0},
		'{MODE_TOKEN, 20'h00001, 1'b0, '0}
	};

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0; s_tuser = MODE_TOKEN; s_tdata = '0; m_tready = 1'b0;
		idle_src = 0; stall_snk = 0;
		n_errors = 0; n_results = 0; n_found = 0; n_full = 0;
		n_clears = 0; n_items = 0; cycles = 0;
		sam_clear();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			send_item(dir_rows[i].mode, dir_rows[i].tok, dir_rows[i].typed, dir_rows[i].res);

		// random phases: idling mix changes, each phase gets runs of varied alphabets
		for (int ph = 0; ph < 4; ph++) begin
			idle_src  = src_phase[ph];
			stall_snk = snk_phase[ph];
			repeat (6)
				send_run(48, $urandom_range(1, 8), 2);
		end

		// a last run from a fresh automaton without idling
		idle_src = 0; stall_snk = 0;
		send_item(MODE_CLEAR, '0, 1'b0, '0);
		send_run(60, 3, 0);
		s_tvalid <= 1'b0;

		while (pending_matches.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("%0d items sent (%0d clears), %0d results checked", n_items, n_clears,
			n_results);
		$display("%0d results with a match, %0d with the store full, %0d mismatches",
			n_found, n_full, n_errors);
		if (n_errors == 0)
			$display("suffix_automaton_match_top_tb: clean");
		else
			$display("suffix_automaton_match_top_tb: errors");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/sam_pkg.sv
hw/rtl/sam_dp.sv
hw/rtl/sam_ctrl.sv
hw/rtl/suffix_automaton_match_top.sv
hw/rtl/sam_chk.sv
bench/suffix_automaton_match_top_tb.sv
